FILE: rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// shared types, action codes and default sizes for the trie word store
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

   // default pool geometry
   localparam int ALPHABET_DEF = 26;
   localparam int NODES_DEF    = 1024;

   // item field widths
   localparam int ACTION_W     = 2;
   localparam int LETTER_W     = 5;
   localparam int NODES_USED_W = 11;

   // action codes, the unused code walks as a prefix check
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PREFIX = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic start;
      logic walk;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic item_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/tws_req_if.sv
// ----------------------------------------------------------------------------
// tws_req_if
// letter item channel into the trie word store
// ----------------------------------------------------------------------------
`default_nettype none

interface tws_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [4:0] letter_index;
   logic       last_letter;

   modport source (output valid, output action, output letter_index, output last_letter,
                   input ready);
   modport sink   (input valid, input action, input letter_index, input last_letter,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/tws_rsp_if.sv
// ----------------------------------------------------------------------------
// tws_rsp_if
// word result channel out of the trie word store
// ----------------------------------------------------------------------------
`default_nettype none

interface tws_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic        pool_full;
   logic [10:0] nodes_used;

   modport source (output valid, output found, output pool_full, output nodes_used,
                   input ready);
   modport sink   (input valid, input found, input pool_full, input nodes_used,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/tws_ram.sv
// ----------------------------------------------------------------------------
// tws_ram
// generic single port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/tws_ctrl.sv
// ----------------------------------------------------------------------------
// tws_ctrl
// sequencer: clearing pass, item accept, child lookup, word finish
// ----------------------------------------------------------------------------
`default_nettype none

module tws_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tws_pkg::status_type status,
   output tws_pkg::cmd_type    cmd
);
   import tws_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            state_in = status.item_last ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/tws_datapath.sv
// ----------------------------------------------------------------------------
// tws_datapath
// cursor, allocator, child table and word mark memories, result register
// ----------------------------------------------------------------------------
`default_nettype none

module tws_datapath #(
   parameter int ALPHABET = tws_pkg::ALPHABET_DEF,
   parameter int NODES    = tws_pkg::NODES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tws_pkg::cmd_type                    cmd,
   output tws_pkg::status_type                 status,
   input  logic [tws_pkg::ACTION_W-1:0]        req_action,
   input  logic [tws_pkg::LETTER_W-1:0]        req_letter_index,
   input  logic                                req_last_letter,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic                                rsp_pool_full,
   output logic [tws_pkg::NODES_USED_W-1:0]    rsp_nodes_used
);
   import tws_pkg::*;

   localparam int TOTAL = NODES * ALPHABET;
   localparam int AW    = $clog2(TOTAL);
   localparam int NW    = $clog2(NODES);
   localparam int FW    = $clog2(NODES + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TOTAL - 1);
   localparam logic [AW-1:0] ALPHA_A   = AW'(ALPHABET);
   localparam logic [AW-1:0] NODES_A   = AW'(NODES);
   localparam logic [FW-1:0] NODES_F   = FW'(NODES);

   logic [AW-1:0]       count_ff, count_in;
   logic [NW-1:0]       cursor_ff, cursor_in;
   logic [FW-1:0]       next_free_ff, next_free_in;
   logic                broken_ff, broken_in;
   logic                failed_ff, failed_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic                last_ff, last_in;
   logic                bad_ff, bad_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   logic                full_ff, full_in;
   logic [NODES_USED_W-1:0] used_ff, used_in;

   logic [AW-1:0] slot_calc;
   logic [FW+NODES_USED_W-1:0] used_ext;

   logic          ct_en, ct_we;
   logic [AW-1:0] ct_addr;
   logic [NW-1:0] ct_wdata, ct_rdata;
   logic          wm_en, wm_we;
   logic [NW-1:0] wm_addr;
   logic [0:0]    wm_wdata, wm_rdata;

   tws_ram #(.WIDTH(NW), .DEPTH(TOTAL)) u_child_table (
      .clock (clock),
      .en    (ct_en),
      .we    (ct_we),
      .addr  (ct_addr),
      .wdata (ct_wdata),
      .rdata (ct_rdata)
   );

   tws_ram #(.WIDTH(1), .DEPTH(NODES)) u_word_mark (
      .clock (clock),
      .en    (wm_en),
      .we    (wm_we),
      .addr  (wm_addr),
      .wdata (wm_wdata),
      .rdata (wm_rdata)
   );

   // row of the cursor node plus letter
   assign slot_calc = AW'(cursor_ff) * ALPHA_A + AW'(req_letter_index);
   // nodes_used reports next free node masked to the field width
   assign used_ext  = (FW + NODES_USED_W)'(next_free_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         next_free_ff <= FW'(1);
         broken_ff    <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         next_free_ff <= next_free_in;
         broken_ff    <= broken_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      last_ff  <= last_in;
      bad_ff   <= bad_in;
      slot_ff  <= slot_in;
      found_ff <= found_in;
      full_ff  <= full_in;
      used_ff  <= used_in;
   end

   always_comb begin
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      next_free_in = next_free_ff;
      broken_in    = broken_ff;
      failed_in    = failed_ff;
      act_in       = act_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      ct_en    = 1'b0;
      ct_we    = 1'b0;
      ct_addr  = slot_ff;
      ct_wdata = '0;
      wm_en    = 1'b0;
      wm_we    = 1'b0;
      wm_addr  = cursor_ff;
      wm_wdata = 1'b0;

      if (cmd.clear_step) begin
         ct_en    = 1'b1;
         ct_we    = 1'b1;
         ct_addr  = count_ff;
         count_in = count_ff + AW'(1);
         if (count_ff < NODES_A) begin
            wm_en   = 1'b1;
            wm_we   = 1'b1;
            wm_addr = count_ff[NW-1:0];
         end
      end

      if (cmd.start) begin
         act_in  = req_action;
         last_in = req_last_letter;
         bad_in  = 32'(req_letter_index) >= ALPHABET;
         slot_in = slot_calc;
         ct_en   = 1'b1;
         ct_addr = slot_calc;
      end

      if (cmd.walk) begin
         if (!broken_ff) begin
            if (bad_ff) begin
               broken_in = 1'b1;
            end else if (ct_rdata != '0) begin
               cursor_in = ct_rdata;
            end else if (act_ff != ACT_INSERT) begin
               broken_in = 1'b1;
            end else if (next_free_ff == NODES_F) begin
               broken_in = 1'b1;
               failed_in = 1'b1;
            end else begin
               // link a fresh node into the missing slot
               ct_en        = 1'b1;
               ct_we        = 1'b1;
               ct_addr      = slot_ff;
               ct_wdata     = next_free_ff[NW-1:0];
               cursor_in    = next_free_ff[NW-1:0];
               next_free_in = next_free_ff + FW'(1);
            end
         end
         // fetch the word mark of the node the cursor lands on
         wm_en   = last_ff;
         wm_addr = cursor_in;
      end

      if (cmd.finish) begin
         if (broken_ff) begin
            found_in = 1'b0;
         end else begin
            case (act_ff)
               ACT_INSERT: begin
                  found_in = 1'b1;
                  wm_en    = 1'b1;
                  wm_we    = 1'b1;
                  wm_addr  = cursor_ff;
                  wm_wdata = 1'b1;
               end
               ACT_SEARCH: found_in = wm_rdata[0];
               default:    found_in = 1'b1;
            endcase
         end
         full_in      = failed_ff;
         used_in      = used_ext[NODES_USED_W-1:0];
         rsp_valid_in = 1'b1;
         cursor_in    = '0;
         broken_in    = 1'b0;
         failed_in    = 1'b0;
      end
   end

   assign status.clear_done = (count_ff == LAST_SLOT);
   assign status.item_last  = last_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_pool_full  = full_ff;
   assign rsp_nodes_used = used_ff;

endmodule

`default_nettype wire

FILE: rtl/trie_word_store_top.sv
// ----------------------------------------------------------------------------
// trie_word_store_top
// lower-case word trie in a fixed node pool, one letter item at a time
// ----------------------------------------------------------------------------
// usage
//   req_if carries one letter per item: action (insert, search, prefix
//   check), letter_index and last_letter. rsp_if carries one result item per
//   word, given on the item that has last_letter set: found, pool_full and
//   nodes_used (nodes taken including the root).
// sequence
//   a letter that is not last is accepted with the child table read, then
//   goes through the walk step that may write a fresh child pointer into the
//   same single port table. a last letter adds a finish step for the word
//   mark read or write. the child table port sets the rate.
// reset
//   synchronous reset starts a clearing pass over the child table and word
//   marks, during which req_if.ready is low.
// stalls
//   the result sits in an output register; letters keep being accepted
//   while it waits. a last letter that finds the register still full waits
//   until rsp_if.ready takes the pending item.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_store_top #(
   parameter int ALPHABET = tws_pkg::ALPHABET_DEF,
   parameter int NODES    = tws_pkg::NODES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   tws_req_if.sink  req_if,
   tws_rsp_if.source rsp_if
);
   import tws_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   tws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tws_datapath #(
      .ALPHABET (ALPHABET),
      .NODES    (NODES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_if.action),
      .req_letter_index (req_if.letter_index),
      .req_last_letter  (req_if.last_letter),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_found        (rsp_if.found),
      .rsp_pool_full    (rsp_if.pool_full),
      .rsp_nodes_used   (rsp_if.nodes_used)
   );

endmodule

`default_nettype wire

FILE: rtl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// port level checks on the trie word store, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tws_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic        rsp_pool_full,
   input logic [10:0] rsp_nodes_used
);

   // clearing pass holds off letters right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("letter item accepted during clearing pass");

   // each letter needs its walk step before another letter is taken
   a_one_letter_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("letter item accepted back to back");

   // a word that ran out of nodes is never stored
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pool_full) |-> !rsp_found)
      else $error("pool_full result reports found");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found)
         && $stable(rsp_pool_full) && $stable(rsp_nodes_used)))
      else $error("stalled result item changed");

endmodule

bind trie_word_store_top tws_checker u_tws_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_found      (rsp_if.found),
   .rsp_pool_full  (rsp_if.pool_full),
   .rsp_nodes_used (rsp_if.nodes_used)
);

`default_nettype wire

FILE: tb/tb_trie_word_store_top.sv
// ----------------------------------------------------------------------------
// tb_trie_word_store_top
// self-checking bench for the trie word store
// ----------------------------------------------------------------------------
// letter items go in one at a time through the request channel. Each accepted
// item is also handed to a scoreboard that keeps its own trie, so every word
// result coming out is compared with what the trie says it should be. The run
// starts with a few hand-picked words, then random dictionary traffic, then
// fills the node pool and keeps going with the pool full.
// ----------------------------------------------------------------------------

module tb_trie_word_store_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tws_pkg::*;

   localparam int ALPHA       = ALPHABET_DEF;
   localparam int POOL        = NODES_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;

   // the fourth action code has no name in the package, it walks as a prefix check
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic                    found;
      logic                    pool_full;
      logic [NODES_USED_W-1:0] nodes_used;
   } word_result_type;

   // ------------------------------------------------------------------------
   // scoreboard: its own copy of the trie, plus the queue of pending results
   // ------------------------------------------------------------------------
   class word_trie_scoreboard;
      bit [9:0]        child_ptr [ALPHA*POOL];
      bit              word_end [POOL];
      int unsigned     next_node;
      int unsigned     cursor;
      bit              broken;
      bit              alloc_failed;
      word_result_type expected_words[$];
      int              mismatches;
      int              words_checked;
      int              full_results;

      function new();
         next_node     = 1;
         cursor        = 0;
         broken        = 0;
         alloc_failed  = 0;
         mismatches    = 0;
         words_checked = 0;
         full_results  = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // walks one accepted letter; queues the word result on the last one
      function void note_letter(logic [1:0] act, logic [4:0] letter, logic last);
         int unsigned     slot;
         int unsigned     child;
         word_result_type want;
         if (!broken) begin
            if (letter >= ALPHA) begin
               broken = 1;
            end else begin
               slot  = cursor * ALPHA + letter;
               child = child_ptr[slot];
               if (child == 0 && act != ACT_INSERT) begin
                  broken = 1;
               end else if (child == 0 && next_node >= POOL) begin
                  alloc_failed = 1;
                  broken       = 1;
               end else begin
                  if (child == 0) begin
                     child           = next_node;
                     child_ptr[slot] = child[9:0];
                     next_node++;
                  end
                  cursor = child;
               end
            end
         end
         if (last) begin
            if (broken) begin
               want.found = 1'b0;
            end else if (act == ACT_INSERT) begin
               word_end[cursor] = 1'b1;
               want.found       = 1'b1;
            end else if (act == ACT_SEARCH) begin
               want.found = word_end[cursor];
            end else begin
               want.found = 1'b1;
            end
            want.pool_full  = alloc_failed;
            want.nodes_used = next_node[NODES_USED_W-1:0];
            expected_words.push_back(want);
            cursor       = 0;
            broken       = 0;
            alloc_failed = 0;
         end
      endfunction

      function void check_result(word_result_type got);
         word_result_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: found=%0b pool_full=%0b nodes_used=%0d",
                        got.found, got.pool_full, got.nodes_used);
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         if (want.pool_full) full_results++;
         if (got.found !== want.found || got.pool_full !== want.pool_full ||
             got.nodes_used !== want.nodes_used) begin
            mismatches++;
            if (mismatches <= 10)
               $display("word %0d: expected found=%0b pool_full=%0b nodes_used=%0d, %s%0b %s%0b %s%0d",
                        words_checked, want.found, want.pool_full, want.nodes_used,
                        "got found=", got.found, "pool_full=", got.pool_full,
                        "nodes_used=", got.nodes_used);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   tws_req_if req_if ();
   tws_rsp_if rsp_if ();

   trie_word_store_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #10 clock = ~clock;

   word_trie_scoreboard sb;
   string vocab[$];          // words inserted so far, reused for hits
   int    letters_sent = 0;
   int    cycle_count  = 0;
   bit    idle_on      = 1;  // random idling on both sides
   bit    hold_wanted  = 0;  // asks the receiver for one long hold-off

   // run limit, far above the slowest legal run including the clearing pass
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // receiver: checks every accepted result, stalls at random, and once
   // holds off long enough that the result register backs up into the input
   // ------------------------------------------------------------------------
   initial begin
      int              hold_left;
      bit              hold_taken;
      word_result_type got;
      hold_left    = 0;
      hold_taken   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got.found      = rsp_if.found;
            got.pool_full  = rsp_if.pool_full;
            got.nodes_used = rsp_if.nodes_used;
            sb.check_result(got);
         end
         if (hold_wanted && !hold_taken) begin
            hold_taken = 1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !(idle_on && $urandom_range(99) < 26);
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender tasks
   // ------------------------------------------------------------------------

   // offers one letter item, waits for it to be taken and tells the scoreboard
   task automatic send_letter(input logic [1:0] act, input logic [4:0] letter,
                              input logic last);
      while (idle_on && $urandom_range(99) < 26) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.action       <= act;
      req_if.letter_index <= letter;
      req_if.last_letter  <= last;
      do @(posedge clock); while (!req_if.ready);
      sb.note_letter(act, letter, last);
      letters_sent++;
   endtask

   // one word, letter by letter; mixed gives each letter its own action,
   // noisy now and then swaps in a letter index past z
   task automatic send_word(input string w, input logic [1:0] act, input bit mixed,
                            input bit noisy);
      logic [1:0] a;
      logic [4:0] l;
      for (int i = 0; i < w.len(); i++) begin
         a = mixed ? 2'($urandom_range(3)) : act;
         l = 5'(w[i] - 8'd97);
         if (noisy && $urandom_range(99) < 3) l = 5'($urandom_range(31, ALPHA));
         send_letter(a, l, i == w.len() - 1);
      end
   endtask

   // stops offering and waits until every word result has come back
   task automatic drain_words();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic string random_letters(int n);
      string s;
      s = "";
      for (int k = 0; k < n; k++) begin
         s = {s, "a"};
         s.putc(k, byte'(8'd97 + 8'($urandom_range(ALPHA - 1))));
      end
      return s;
   endfunction

   // a stored word, a prefix or extension of one, or a fresh word
   function automatic string pick_word();
      string w;
      if (vocab.size() > 0 && $urandom_range(99) < 45) begin
         w = vocab[$urandom_range(vocab.size() - 1)];
         case ($urandom_range(3))
            0: w = w.substr(0, $urandom_range(w.len() - 1));
            1: w = {w, random_letters(1 + $urandom_range(2))};
            default: ;
         endcase
      end else begin
         w = random_letters($urandom_range(1, ($urandom_range(99) < 8) ? 12 : 5));
      end
      return w;
   endfunction

   task automatic send_random_word();
      string w;
      int    pick;
      w    = pick_word();
      pick = $urandom_range(99);
      if (pick < 40) begin
         send_word(w, ACT_INSERT, 0, 1);
         vocab.push_back(w);
      end else if (pick < 65) begin
         send_word(w, ACT_SEARCH, 0, 1);
      end else if (pick < 85) begin
         send_word(w, ACT_PREFIX, 0, 1);
      end else if (pick < 92) begin
         send_word(w, ACT_SPARE, 0, 1);
      end else begin
         send_word(w, ACT_INSERT, 1, 1);
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      string w;
      int    mixed_end;
      int    full_end;
      req_if.valid        = 1'b0;
      req_if.action       = ACT_INSERT;
      req_if.letter_index = '0;
      req_if.last_letter  = 1'b0;
      reset               = 1'b1;
      sb                  = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // hand-picked words; the block clears its pool first, ready stays low
      send_letter(ACT_INSERT, 5'd0, 1);          // "a"
      send_letter(ACT_INSERT, 5'd25, 0);         // "zb"
      send_letter(ACT_INSERT, 5'd1, 1);
      send_letter(ACT_SEARCH, 5'd25, 0);         // hit on a stored word
      send_letter(ACT_SEARCH, 5'd1, 1);
      send_letter(ACT_SEARCH, 5'd25, 1);         // path exists but no word end
      send_letter(ACT_PREFIX, 5'd25, 1);
      send_letter(ACT_SPARE, 5'd25, 1);          // spare code walks as prefix
      send_letter(ACT_SEARCH, 5'd16, 1);         // missing child on the last letter
      send_letter(ACT_SEARCH, 5'd16, 0);         // break, then a letter that is ignored
      send_letter(ACT_SEARCH, 5'd0, 1);
      send_letter(ACT_INSERT, 5'd31, 1);         // letter past z: no store, no full flag
      send_letter(ACT_INSERT, 5'd0, 0);          // letter past z in the middle
      send_letter(ACT_INSERT, 5'd26, 0);
      send_letter(ACT_INSERT, 5'd1, 1);
      send_letter(ACT_PREFIX, 5'd30, 1);
      send_letter(ACT_SEARCH, 5'd31, 0);
      send_letter(ACT_SEARCH, 5'd0, 1);
      send_letter(ACT_INSERT, 5'd2, 0);          // mixed: insert then search
      send_letter(ACT_SEARCH, 5'd3, 1);
      send_letter(ACT_SEARCH, 5'd25, 0);         // mixed: search then insert
      send_letter(ACT_INSERT, 5'd24, 1);
      send_letter(ACT_PREFIX, 5'd25, 0);
      send_letter(ACT_PREFIX, 5'd24, 1);
      vocab.push_back("a");
      vocab.push_back("zb");
      vocab.push_back("zy");

      // sender pause: everything in flight comes back before going on
      drain_words();

      // random dictionary traffic, with a stretch without random idling and the long hold-off
      mixed_end = letters_sent + 150;
      while (letters_sent < mixed_end) begin
         idle_on = !(letters_sent >= 30 && letters_sent < 100);
         if (letters_sent >= 110) hold_wanted = 1;
         send_random_word();
      end
      idle_on = 1;

      // long fresh inserts until the pool runs out, a few lookups mixed in
      while (sb.next_node < POOL) begin
         if ($urandom_range(99) < 6) begin
            send_word(vocab[$urandom_range(vocab.size() - 1)], ACT_SEARCH, 0, 0);
         end else begin
            w = random_letters($urandom_range(8, 16));
            send_word(w, ACT_INSERT, 0, 0);
            vocab.push_back(w);
         end
      end

      // pool full: inserts that need a node fail, lookups still work;
      // also words that fail an insert letter and end with a search
      for (int n = 0; n < 5; n++) begin
         w = random_letters(6);
         for (int i = 0; i < 5; i++) send_letter(ACT_INSERT, 5'(w[i] - 8'd97), 0);
         send_letter(ACT_SEARCH, 5'(w[5] - 8'd97), 1);
      end
      full_end = letters_sent + 40;
      while (letters_sent < full_end) send_random_word();

      // wind down and give the block time to show anything extra
      drain_words();
      repeat (20) @(posedge clock);

      $display("words checked: %0d from %0d letter items, %0d reported a full pool",
               sb.words_checked, letters_sent, sb.full_results);
      $display("pool reached %0d of %0d nodes, %0d mismatches",
               sb.next_node, POOL, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/tws_pkg.sv
rtl/tws_req_if.sv
rtl/tws_rsp_if.sv
rtl/tws_ram.sv
rtl/tws_ctrl.sv
rtl/tws_datapath.sv
rtl/trie_word_store_top.sv
rtl/tws_checker.sv
tb/tb_trie_word_store_top.sv
